// ----- rtl/pss_pkg.sv -----
package pss_pkg;

	localparam int QUANTUM_W    = 16;
	localparam int TIME_W       = 32;
	localparam int ARR_W        = 16;
	localparam int EXEC_W       = 16;
	localparam int WEIGHT_W     = 10;
	localparam int TOTAL_W      = 14;
	localparam int SLICE_W      = 16;
	localparam int KIND_W       = 2;
	localparam int PROC_ID_W    = 5;
	localparam int PROD_W       = WEIGHT_W + QUANTUM_W;
	localparam int RESULT_LIMIT = 16;
	localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;

	typedef enum logic [KIND_W-1:0] {
		EV_EXEC     = 2'd0,
		EV_IDLE     = 2'd1,
		EV_FINISHED = 2'd2
	} event_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;         // store one table entry from the input ports
		logic run_fin;      // report that every process is done
		logic scan_init;    // rewind the scan
		logic rd;           // read the entry under the scan index
		logic skip;         // entry not ready, move on
		logic div_start;    // start the slice division
		logic apply;        // charge the slice and move on
		logic finish_scan;  // flush the held result or report an idle tick
	} pss_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic all_done;
		logic scan_end;
		logic ready;
		logic zero_total;
		logic div_done;
	} pss_status_t;

endpackage

// ----- rtl/pss_table.sv -----
module pss_table #(
	parameter int MAX_PROCS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tab_we,
	input  logic                          rem_we,
	input  logic                          flag_set,
	input  logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] wr_addr,
	input  logic [pss_pkg::ARR_W-1:0]     arrival_wdata,
	input  logic [pss_pkg::EXEC_W-1:0]    rem_wdata,
	input  logic [pss_pkg::WEIGHT_W-1:0]  weight_wdata,
	input  logic                          rd_en,
	input  logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] rd_addr,
	output logic [pss_pkg::ARR_W-1:0]     arrival_rd,
	output logic [pss_pkg::EXEC_W-1:0]    remaining_rd,
	output logic [pss_pkg::WEIGHT_W-1:0]  weight_rd,
	output logic                          flag_rd
);
	import pss_pkg::*;

	logic [ARR_W-1:0]    arrival_mem   [MAX_PROCS];
	logic [EXEC_W-1:0]   remaining_mem [MAX_PROCS];
	logic [WEIGHT_W-1:0] weight_mem    [MAX_PROCS];
	logic [MAX_PROCS-1:0] completed_q;

	always_ff @(posedge clk) begin
		if (tab_we) begin
			arrival_mem[wr_addr] <= arrival_wdata;
			weight_mem[wr_addr]  <= weight_wdata;
		end
		if (rem_we) begin
			remaining_mem[wr_addr] <= rem_wdata;
		end
		if (rd_en) begin
			arrival_rd   <= arrival_mem[rd_addr];
			remaining_rd <= remaining_mem[rd_addr];
			weight_rd    <= weight_mem[rd_addr];
		end
	end

	// Completion flags clear at reset, so they live in flip-flops.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			completed_q <= '0;
		end else if (flag_set) begin
			completed_q[wr_addr] <= 1'b1;
		end else if (tab_we) begin
			completed_q[wr_addr] <= 1'b0;
		end
	end

	assign flag_rd = completed_q[rd_addr];

endmodule

// ----- rtl/pss_div.sv -----
module pss_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [pss_pkg::PROD_W-1:0]  dividend,
	input  logic [pss_pkg::TOTAL_W-1:0] divisor,
	output logic                        done,
	output logic [pss_pkg::PROD_W-1:0]  quot
);
	import pss_pkg::*;

	localparam int STEP_W = $clog2(PROD_W);

	logic [TOTAL_W-1:0] rem_q;
	logic [PROD_W-1:0]  quo_q;
	logic [STEP_W-1:0]  step_q;
	logic               run_q;
	logic [TOTAL_W:0]   trial;
	logic               fits;

	// Restoring division, one quotient bit per cycle.
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign done  = run_q && (step_q == STEP_W'(PROD_W - 1));
	assign quot  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			step_q <= '0;
		end else if (run_q) begin
			step_q <= step_q + 1'b1;
			if (done) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= fits ? TOTAL_W'(trial - {1'b0, divisor}) : TOTAL_W'(trial);
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

endmodule

// ----- rtl/pss_datapath.sv -----
module pss_datapath #(
	parameter int MAX_PROCS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pss_pkg::pss_cmd_t              cmd,
	output pss_pkg::pss_status_t           status,
	input  logic                           cfg_we,
	input  logic [pss_pkg::QUANTUM_W-1:0]  cfg_wdata,
	input  logic [pss_pkg::ARR_W-1:0]      arrival_time,
	input  logic [pss_pkg::EXEC_W-1:0]     exec_time,
	input  logic [pss_pkg::WEIGHT_W-1:0]   proc_weight,
	output logic                           result_valid,
	output logic [pss_pkg::KIND_W-1:0]     event_kind,
	output logic [pss_pkg::PROC_ID_W-1:0]  proc_id,
	output logic [pss_pkg::TIME_W-1:0]     start_time,
	output logic [pss_pkg::SLICE_W-1:0]    slice_len,
	output logic                           done_flag,
	output logic [pss_pkg::TIME_W-1:0]     end_time,
	output logic                           last
);
	import pss_pkg::*;

	localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W = $clog2(MAX_PROCS + 1);

	logic [QUANTUM_W-1:0] quantum_q;
	logic [CNT_W-1:0]     loaded_q;
	logic [CNT_W-1:0]     finished_q;
	logic [TIME_W-1:0]    time_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [CNT_W-1:0]     idx_q;
	logic [RES_CNT_W-1:0] res_cnt_q;

	// Executed result held back until it is known whether it is the last one.
	logic                 pend_valid_q;
	logic [PROC_ID_W-1:0] pend_id_q;
	logic [TIME_W-1:0]    pend_start_q;
	logic [SLICE_W-1:0]   pend_slice_q;
	logic                 pend_done_q;
	logic [TIME_W-1:0]    pend_end_q;

	logic                 out_valid_q;
	logic [KIND_W-1:0]    out_kind_q;
	logic [PROC_ID_W-1:0] out_id_q;
	logic [TIME_W-1:0]    out_start_q;
	logic [SLICE_W-1:0]   out_slice_q;
	logic                 out_done_q;
	logic [TIME_W-1:0]    out_end_q;
	logic                 out_last_q;

	logic                 can_load;
	logic                 tab_we;
	logic                 rem_we;
	logic                 flag_set;
	logic [IDX_W-1:0]     wr_addr;
	logic [EXEC_W-1:0]    rem_wdata;
	logic [ARR_W-1:0]     arrival_rd;
	logic [EXEC_W-1:0]    remaining_rd;
	logic [WEIGHT_W-1:0]  weight_rd;
	logic                 flag_rd;
	logic                 div_done;
	logic [PROD_W-1:0]    quot;
	logic [PROD_W-1:0]    dividend;
	logic [SLICE_W-1:0]   slice;
	logic                 done_now;
	logic [TIME_W-1:0]    new_time;
	logic [TIME_W-1:0]    idle_end;
	logic [CNT_W:0]       id_ext;

	assign can_load = loaded_q < CNT_W'(MAX_PROCS);
	assign tab_we   = cmd.load && can_load;
	assign done_now = slice >= remaining_rd;
	assign rem_we   = tab_we || cmd.apply;
	assign flag_set = cmd.apply && done_now;
	assign wr_addr  = cmd.load ? loaded_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
	assign rem_wdata = cmd.load ? exec_time :
		(done_now ? '0 : EXEC_W'(remaining_rd - slice));
	assign dividend = PROD_W'(weight_rd) * PROD_W'(quantum_q);

	pss_table #(
		.MAX_PROCS(MAX_PROCS)
	) u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.tab_we       (tab_we),
		.rem_we       (rem_we),
		.flag_set     (flag_set),
		.wr_addr      (wr_addr),
		.arrival_wdata(arrival_time),
		.rem_wdata    (rem_wdata),
		.weight_wdata (proc_weight),
		.rd_en        (cmd.rd),
		.rd_addr      (idx_q[IDX_W-1:0]),
		.arrival_rd   (arrival_rd),
		.remaining_rd (remaining_rd),
		.weight_rd    (weight_rd),
		.flag_rd      (flag_rd)
	);

	pss_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dividend),
		.divisor (total_q),
		.done    (div_done),
		.quot    (quot)
	);

	// Slice is the quotient, at least 1 and at most the slice field's range.
	always_comb begin
		if (total_q == '0) begin
			slice = SLICE_W'(1);
		end else if (|quot[PROD_W-1:SLICE_W]) begin
			slice = '1;
		end else if (quot == '0) begin
			slice = SLICE_W'(1);
		end else begin
			slice = quot[SLICE_W-1:0];
		end
	end

	assign new_time = time_q + TIME_W'(slice);
	assign idle_end = time_q + TIME_W'(1);
	assign id_ext   = {1'b0, idx_q} + (CNT_W+1)'(1);

	assign status.all_done   = finished_q >= loaded_q;
	assign status.scan_end   = (idx_q == loaded_q) ||
		(res_cnt_q == RES_CNT_W'(RESULT_LIMIT));
	assign status.ready      = !flag_rd && (TIME_W'(arrival_rd) <= time_q);
	assign status.zero_total = total_q == '0;
	assign status.div_done   = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q    <= QUANTUM_RESET;
			loaded_q     <= '0;
			finished_q   <= '0;
			time_q       <= '0;
			total_q      <= '0;
			idx_q        <= '0;
			res_cnt_q    <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			if (tab_we) begin
				loaded_q <= loaded_q + 1'b1;
				total_q  <= total_q + TOTAL_W'(proc_weight);
			end
			if (cmd.run_fin) begin
				out_valid_q <= 1'b1;
			end
			if (cmd.scan_init) begin
				idx_q        <= '0;
				res_cnt_q    <= '0;
				pend_valid_q <= 1'b0;
			end
			if (cmd.skip) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.apply) begin
				idx_q        <= idx_q + 1'b1;
				res_cnt_q    <= res_cnt_q + 1'b1;
				time_q       <= new_time;
				pend_valid_q <= 1'b1;
				out_valid_q  <= pend_valid_q;
				if (done_now) begin
					finished_q <= finished_q + 1'b1;
					total_q    <= total_q - TOTAL_W'(weight_rd);
				end
			end
			if (cmd.finish_scan) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
				if (!pend_valid_q) begin
					time_q <= idle_end;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			pend_id_q    <= PROC_ID_W'(id_ext);
			pend_start_q <= time_q;
			pend_slice_q <= slice;
			pend_done_q  <= done_now;
			pend_end_q   <= new_time;
		end
		if (cmd.run_fin) begin
			out_kind_q  <= EV_FINISHED;
			out_id_q    <= '0;
			out_start_q <= time_q;
			out_slice_q <= '0;
			out_done_q  <= 1'b0;
			out_end_q   <= time_q;
			out_last_q  <= 1'b1;
		end else if (cmd.apply || (cmd.finish_scan && pend_valid_q)) begin
			out_kind_q  <= EV_EXEC;
			out_id_q    <= pend_id_q;
			out_start_q <= pend_start_q;
			out_slice_q <= pend_slice_q;
			out_done_q  <= pend_done_q;
			out_end_q   <= pend_end_q;
			out_last_q  <= cmd.finish_scan;
		end else if (cmd.finish_scan) begin
			out_kind_q  <= EV_IDLE;
			out_id_q    <= '0;
			out_start_q <= time_q;
			out_slice_q <= SLICE_W'(1);
			out_done_q  <= 1'b0;
			out_end_q   <= idle_end;
			out_last_q  <= 1'b1;
		end
	end

	assign result_valid = out_valid_q;
	assign event_kind   = out_kind_q;
	assign proc_id      = out_id_q;
	assign start_time   = out_start_q;
	assign slice_len    = out_slice_q;
	assign done_flag    = out_done_q;
	assign end_time     = out_end_q;
	assign last         = out_last_q;

endmodule

// ----- rtl/pss_ctrl.sv -----
module pss_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 mode,
	input  pss_pkg::pss_status_t status,
	output pss_pkg::pss_cmd_t    cmd,
	output logic                 busy
);
	import pss_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_CHECK = 6'b000100,
		S_DIV   = 6'b001000,
		S_APPLY = 6'b010000,
		S_END   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		busy       = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (!mode) begin
						cmd.load = 1'b1;
					end else if (status.all_done) begin
						cmd.run_fin = 1'b1;
					end else begin
						cmd.scan_init = 1'b1;
						state_next    = S_READ;
					end
				end
			end
			S_READ: begin
				if (status.scan_end) begin
					state_next = S_END;
				end else begin
					cmd.rd     = 1'b1;
					state_next = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!status.ready) begin
					cmd.skip   = 1'b1;
					state_next = S_READ;
				end else if (status.zero_total) begin
					state_next = S_APPLY;
				end else begin
					cmd.div_start = 1'b1;
					state_next    = S_DIV;
				end
			end
			S_DIV: begin
				if (status.div_done) begin
					state_next = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply  = 1'b1;
				state_next = S_READ;
			end
			S_END: begin
				cmd.finish_scan = 1'b1;
				state_next      = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ----- rtl/proportional_share_scheduler.sv -----
// A load item gives no result; a run item with nothing left to do gives its finished
// result in the cycle after it is accepted.
// A scan reads each entry in turn and skips one that is not ready; a ready entry goes
// through the divider, or straight to charging when the weight total is zero. One
// item is worked on at a time; busy is high while a scan runs, and the receiver
// cannot stall results. Reset clears the table flags, counters, time and total, and
// returns the quantum to 10.
module proportional_share_scheduler #(
	parameter int MAX_PROCS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           cfg_we,
	input  logic [pss_pkg::QUANTUM_W-1:0]  cfg_wdata,
	input  logic                           mode,
	input  logic [pss_pkg::ARR_W-1:0]      arrival_time,
	input  logic [pss_pkg::EXEC_W-1:0]     exec_time,
	input  logic [pss_pkg::WEIGHT_W-1:0]   proc_weight,
	output logic                           result_valid,
	output logic [pss_pkg::KIND_W-1:0]     event_kind,
	output logic [pss_pkg::PROC_ID_W-1:0]  proc_id,
	output logic [pss_pkg::TIME_W-1:0]     start_time,
	output logic [pss_pkg::SLICE_W-1:0]    slice_len,
	output logic                           done_flag,
	output logic [pss_pkg::TIME_W-1:0]     end_time,
	output logic                           last
);
	import pss_pkg::*;

	// The controller sequences a scan: it reads one table entry, checks whether the
	// process has arrived and is still unfinished, and if so starts the slice division
	// of weight times quantum by the weight total (skipped when the total is zero). When
	// the quotient is ready the datapath charges the slice, advances time and, when the
	// process completes, removes its weight from the total.
	//
	// Each executed result is held one step in the datapath. It goes out when the next
	// ready entry is charged, or at the end of the scan with last set. A scan that
	// charged nothing reports a single idle tick instead.

	pss_cmd_t    cmd;
	pss_status_t status;

	pss_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.mode  (mode),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	// The datapath holds the quantum register, the process table, the divider and the
	// result registers. Each result shows for exactly one cycle under result_valid.
	pss_datapath #(
		.MAX_PROCS(MAX_PROCS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.arrival_time (arrival_time),
		.exec_time    (exec_time),
		.proc_weight  (proc_weight),
		.result_valid (result_valid),
		.event_kind   (event_kind),
		.proc_id      (proc_id),
		.start_time   (start_time),
		.slice_len    (slice_len),
		.done_flag    (done_flag),
		.end_time     (end_time),
		.last         (last)
	);

endmodule
